// ===== hw/rtl/lk_sync_pkg.sv =====
// types, codes and helpers shared by the link keepalive and clock-sync tracker
`timescale 1ns / 1ps

package lk_sync_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_RECEIVED   = 3'd1,
    OP_PING_RESNT = 3'd2,
    OP_SYNC_SENT  = 3'd3,
    OP_UNSYNC     = 3'd4,
    OP_SYNC_REPLY = 3'd5,
    OP_PING_REPLY = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    REG_PING_PERIOD   = 2'd0,
    REG_RESEND_PERIOD = 2'd1,
    REG_SYNC_PERIOD   = 2'd2,
    REG_REPLIES_NEED  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_ADD  = 2'd2,
    S_LOAD = 2'd3
  } state_t;

  // one quotient bit per cycle over a 33-bit magnitude
  localparam int unsigned DivSteps = 33;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [15:0] PingPeriodRst   = 16'd1000;
  localparam logic [15:0] ResendPeriodRst = 16'd200;
  localparam logic [15:0] SyncPeriodRst   = 16'd1000;
  localparam logic [7:0]  RepliesNeedRst  = 8'd4;

  // clamp a 34-bit signed value to the int32 range
  function automatic logic [31:0] sat_i32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/link_keepalive_time_sync.sv =====
// top level of the link keepalive and clock-sync tracker
`timescale 1ns / 1ps

// Keepalive and clock-sync tracker for one link peer. Each accepted word is one
// event and yields exactly one status word. Most events update the state at the
// accepting edge and then load the status word in S_LOAD once the output register
// is free, and no new event is taken before that load. A sync reply first passes
// through S_DIV and S_ADD: the restoring divider forms the running mean one
// quotient bit per cycle over 33 steps, and S_ADD adds the quotient to the mean.
// in_stall is high from acceptance until the status word has been
// loaded into the output register; a loaded word waits there while the next
// event is already being accepted and worked on.
module link_keepalive_time_sync (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic signed [31:0] in_event_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_next_ping_ms,
  output logic signed [31:0] out_next_sync_ms,
  output logic        out_is_synced,
  output logic [30:0] out_round_trip_ms,
  output logic [7:0]  out_ping_attempts,
  output logic signed [31:0] out_clock_offset_ms
);
  import lk_sync_pkg::*;

  state_t state_r, state_nxt;

  logic [15:0] ping_period_r, resend_period_r, sync_period_r;
  logic [7:0]  replies_need_r;

  logic [31:0] now_r, since_ping_r, since_sync_r;
  logic [15:0] cur_period_r;
  logic [7:0]  attempts_r;
  logic [15:0] reply_cnt_r;
  logic [31:0] mean_r;
  logic [30:0] rtt_r;

  // divider
  logic [32:0]        quo_r;
  logic [15:0]        rem_r;
  logic               neg_r;
  logic [DivCntW-1:0] div_cnt_r;

  logic        acc, out_free, load_out, div_step;
  op_t         op;
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic [16:0] rem_sh;
  logic        ge;
  logic [16:0] rem_sub;
  logic signed [33:0] q_signed, mean_sum, rtt_full, np_full, ns_full;

  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign op       = op_t'(in_operation);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = (op == OP_SYNC_REPLY) ? S_DIV : S_LOAD;
        end
      end
      S_DIV: begin
        if (div_cnt_r == DivCntW'(DivSteps - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD:  state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state decoded controls
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    div_step = 1'b0;
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_DIV:   div_step = 1'b1;
      S_ADD:   ;
      S_LOAD:  load_out = out_free;
      default: ;
    endcase
  end

  // shared datapath pieces
  always_comb begin
    diff     = 33'(in_event_value) - 33'(signed'(mean_r));
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    rem_sh   = {rem_r, quo_r[32]};
    ge       = rem_sh >= {1'b0, reply_cnt_r};
    rem_sub  = rem_sh - {1'b0, reply_cnt_r};
    q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    mean_sum = 34'(signed'(mean_r)) + q_signed;
    rtt_full = $signed({2'b00, now_r})
             - (34'(in_event_value) + 34'(signed'(mean_r)));
    np_full  = $signed({18'd0, cur_period_r}) - $signed({2'b00, since_ping_r});
    ns_full  = $signed({18'd0, sync_period_r}) - $signed({2'b00, since_sync_r});
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_period_r   <= PingPeriodRst;
      resend_period_r <= ResendPeriodRst;
      sync_period_r   <= SyncPeriodRst;
      replies_need_r  <= RepliesNeedRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PING_PERIOD:   ping_period_r   <= cfg_wdata;
        REG_RESEND_PERIOD: resend_period_r <= cfg_wdata;
        REG_SYNC_PERIOD:   sync_period_r   <= cfg_wdata;
        REG_REPLIES_NEED:  replies_need_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      now_r        <= '0;
      since_ping_r <= '0;
      since_sync_r <= '0;
      cur_period_r <= PingPeriodRst;
      attempts_r   <= '0;
      reply_cnt_r  <= '0;
      mean_r       <= '0;
      rtt_r        <= '0;
      div_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        div_cnt_r <= '0;
        unique case (op)
          OP_TICK: begin
            now_r <= now_r + 32'd1;
            if (since_ping_r != '1) since_ping_r <= since_ping_r + 32'd1;
            if (since_sync_r != '1) since_sync_r <= since_sync_r + 32'd1;
          end
          OP_RECEIVED: begin
            since_ping_r <= '0;
            cur_period_r <= ping_period_r;
            attempts_r   <= '0;
          end
          OP_PING_RESNT: begin
            since_ping_r <= '0;
            cur_period_r <= resend_period_r;
            if (attempts_r != '1) attempts_r <= attempts_r + 8'd1;
          end
          OP_SYNC_SENT: since_sync_r <= '0;
          OP_UNSYNC:    reply_cnt_r  <= '0;
          OP_SYNC_REPLY: begin
            if (reply_cnt_r != '1) reply_cnt_r <= reply_cnt_r + 16'd1;
          end
          OP_PING_REPLY: begin
            // no estimate until a sync reply has arrived
            if (reply_cnt_r != '0) begin
              if (rtt_full[33]) begin
                rtt_r <= '0;
              end else if (rtt_full[32:31] != 2'b00) begin
                rtt_r <= '1;
              end else begin
                rtt_r <= rtt_full[30:0];
              end
            end
          end
          default: ;
        endcase
      end
      if (div_step) begin
        div_cnt_r <= div_cnt_r + DivCntW'(1);
      end
      if (state_r == S_ADD) begin
        // result lies between old mean and sample, no overflow
        mean_r <= mean_sum[31:0];
      end
    end
  end

  // divider payload
  always_ff @(posedge clk) begin
    if (acc) begin
      quo_r <= diff_mag;
      neg_r <= diff[32];
      rem_r <= '0;
    end else if (div_step) begin
      rem_r <= ge ? rem_sub[15:0] : rem_sh[15:0];
      quo_r <= {quo_r[31:0], ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_next_ping_ms    <= sat_i32(np_full);
      out_next_sync_ms    <= sat_i32(ns_full);
      out_is_synced       <= reply_cnt_r >= {8'd0, replies_need_r};
      out_round_trip_ms   <= rtt_r;
      out_ping_attempts   <= attempts_r;
      out_clock_offset_ms <= mean_r;
    end
  end

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r != S_IDLE)
    else $error("accepted word did not start work");

  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_cnt_r < DivCntW'(DivSteps))
    else $error("divider step count overran");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_LOAD))
    else $error("status word appeared outside output load");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_step |-> reply_cnt_r != '0)
    else $error("divide by zero reply count");

endmodule
